>>> hdl/qau_pkg.sv
// Package: shared types, constants and arithmetic helpers for the quaternion unit.
package qau_pkg;

    localparam int FRAC_BITS = 30;
    localparam int DW        = 32;
    localparam int PW        = 64;
    localparam int AW        = 68;

    typedef enum logic [1:0] {
        ACT_PRODUCT = 2'd0,
        ACT_ROTATE  = 2'd1,
        ACT_MATRIX  = 2'd2,
        ACT_CONJ    = 2'd3
    } action_t;

    typedef logic signed [DW-1:0] word_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [AW-1:0] acc_t;

    // One multiply-accumulate term: operand pair and a signed weight.
    typedef struct packed {
        word_t      x;
        word_t      y;
        logic       neg;
        logic       dbl;
    } term_t;

    typedef struct packed {
        action_t    act;
        logic       sat;
    } ctl_t;

    // Weight a product by -2, -1, 1 or 2, sign-extended to accumulator width.
    function automatic acc_t weigh(input prod_t p, input logic neg, input logic dbl);
        acc_t e;
        e = acc_t'(p);
        if (dbl) e = e <<< 1;
        if (neg) e = -e;
        return e;
    endfunction

    // Round half up, shift and saturate; sets sat on clipping.
    function automatic word_t finish(input acc_t a, output logic sat);
        acc_t r;
        r = (a + (acc_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > acc_t'(32'sh7FFFFFFF)) begin
            sat = 1'b1;
            return word_t'(32'sh7FFFFFFF);
        end else if (r < -(acc_t'(1) <<< (DW - 1))) begin
            sat = 1'b1;
            return word_t'(32'sh80000000);
        end
        sat = 1'b0;
        return r[DW-1:0];
    endfunction

endpackage

>>> hdl/qau_mac4.sv
// Four-term product stage: registered products with their weights.
module qau_mac4 import qau_pkg::*; (
    input  logic            aclk,
    input  logic            en,
    input  term_t [3:0]     t,
    output prod_t [3:0]     p_o,
    output logic  [3:0]     neg_o,
    output logic  [3:0]     dbl_o
);
    prod_t [3:0] p_reg;
    logic  [3:0] neg_reg, dbl_reg;

    // Register each product before summation.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                p_reg[i]   <= prod_t'(t[i].x) * prod_t'(t[i].y);
                neg_reg[i] <= t[i].neg;
                dbl_reg[i] <= t[i].dbl;
            end
        end
    end

    assign p_o   = p_reg;
    assign neg_o = neg_reg;
    assign dbl_o = dbl_reg;
endmodule

>>> hdl/qau_sum.sv
// Summation stage for a group of weighted products.
module qau_sum import qau_pkg::*; (
    input  logic            aclk,
    input  logic            en,
    input  prod_t [3:0]     p,
    input  logic  [3:0]     neg,
    input  logic  [3:0]     dbl,
    output acc_t            acc_o
);
    acc_t acc_reg;

    // Add the four weighted products.
    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg <= weigh(p[0], neg[0], dbl[0]) + weigh(p[1], neg[1], dbl[1])
                     + weigh(p[2], neg[2], dbl[2]) + weigh(p[3], neg[3], dbl[3]);
        end
    end

    assign acc_o = acc_reg;
endmodule

>>> hdl/quaternion_arith_unit_top.sv
// Top level: quaternion product, vector rotation, matrix conversion and conjugate.
//
// Input channel s_*: action plus quaternions A and B (B's x, y, z is the vector
// for a rotation). Result channel m_*: nine Q2.30 words and a saturation flag.
// One result item for every input item, in order.
// Throughput: one item per cycle, sustained, with no stalls downstream.
// Pipeline: an accepted item passes seven register stages before m_valid rises:
// the input register; pass one (product, sum, round) forms A*B, the DCM terms,
// or the rotation's intermediate t = A*(0,v); pass two (product, sum) forms
// t*conj(A), and its rounding feeds the output register, which is the seventh
// stage. Each product is one 32x32 multiplier.
// Reset clears all valid bits; payload registers are not reset.
// When the output holds an item and m_ready is low the whole pipeline holds;
// s_ready drops only while the output register holds an item and cannot move
// it on, so nothing is lost.
module quaternion_arith_unit_top import qau_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic signed [31:0] s_a_w,
    input  logic signed [31:0] s_a_x,
    input  logic signed [31:0] s_a_y,
    input  logic signed [31:0] s_a_z,
    input  logic signed [31:0] s_b_w,
    input  logic signed [31:0] s_b_x,
    input  logic signed [31:0] s_b_y,
    input  logic signed [31:0] s_b_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_out_0,
    output logic signed [31:0] m_out_1,
    output logic signed [31:0] m_out_2,
    output logic signed [31:0] m_out_3,
    output logic signed [31:0] m_out_4,
    output logic signed [31:0] m_out_5,
    output logic signed [31:0] m_out_6,
    output logic signed [31:0] m_out_7,
    output logic signed [31:0] m_out_8,
    output logic        m_saturated
);
    localparam int NS = 7;

    logic [NS-1:0] vld_reg;
    logic          adv;

    // Advance the whole pipeline when the output slot is free or drains.
    assign adv     = !vld_reg[NS-1] || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NS-2:0], s_valid};
        end
    end

    // Stage 0: capture inputs.
    action_t   act0_reg;
    word_t [3:0] qa0_reg, qb0_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            act0_reg <= action_t'(s_action);
            qa0_reg  <= {s_a_z, s_a_y, s_a_x, s_a_w};
            qb0_reg  <= {s_b_z, s_b_y, s_b_x, s_b_w};
        end
    end

    word_t w, x, y, z, bw, bx, by, bz;
    assign {z, y, x, w}     = qa0_reg;
    assign {bz, by, bx, bw} = qb0_reg;

    // Pass one term selection: nine groups of four terms.
    term_t [8:0][3:0] t1;
    localparam term_t TZ = '{x: '0, y: '0, neg: 1'b0, dbl: 1'b0};
    function automatic term_t mk(input word_t a, input word_t b, input logic n, input logic d);
        return '{x: a, y: b, neg: n, dbl: d};
    endfunction

    always_comb begin
        t1 = '{default: TZ};
        case (act0_reg)
            ACT_PRODUCT: begin
                t1[0] = {mk(w,bw,0,0), mk(x,bx,1,0), mk(y,by,1,0), mk(z,bz,1,0)};
                t1[1] = {mk(w,bx,0,0), mk(x,bw,0,0), mk(y,bz,0,0), mk(z,by,1,0)};
                t1[2] = {mk(w,by,0,0), mk(y,bw,0,0), mk(z,bx,0,0), mk(x,bz,1,0)};
                t1[3] = {mk(w,bz,0,0), mk(z,bw,0,0), mk(x,by,0,0), mk(y,bx,1,0)};
            end
            ACT_ROTATE: begin
                t1[0] = {mk(x,bx,1,0), mk(y,by,1,0), mk(z,bz,1,0), TZ};
                t1[1] = {mk(w,bx,0,0), mk(y,bz,0,0), mk(z,by,1,0), TZ};
                t1[2] = {mk(w,by,0,0), mk(z,bx,0,0), mk(x,bz,1,0), TZ};
                t1[3] = {mk(w,bz,0,0), mk(x,by,0,0), mk(y,bx,1,0), TZ};
            end
            ACT_MATRIX: begin
                t1[0] = {mk(w,w,0,0), mk(x,x,0,0), mk(y,y,1,0), mk(z,z,1,0)};
                t1[1] = {mk(x,y,0,1), mk(w,z,1,1), TZ, TZ};
                t1[2] = {mk(x,z,0,1), mk(w,y,0,1), TZ, TZ};
                t1[3] = {mk(x,y,0,1), mk(w,z,0,1), TZ, TZ};
                t1[4] = {mk(w,w,0,0), mk(x,x,1,0), mk(y,y,0,0), mk(z,z,1,0)};
                t1[5] = {mk(y,z,0,1), mk(w,x,1,1), TZ, TZ};
                t1[6] = {mk(x,z,0,1), mk(w,y,1,1), TZ, TZ};
                t1[7] = {mk(y,z,0,1), mk(w,x,0,1), TZ, TZ};
                t1[8] = {mk(w,w,0,0), mk(x,x,1,0), mk(y,y,1,0), mk(z,z,0,0)};
            end
            default: begin
            end
        endcase
    end

    // Pass one: multiply (stage 1), sum (stage 2), round (stage 3).
    prod_t [8:0][3:0] p1;
    logic  [8:0][3:0] n1, d1;
    acc_t  [8:0]      s1;
    for (genvar g = 0; g < 9; g++) begin : g_p1
        qau_mac4 u_mac (.aclk(aclk), .en(adv), .t(t1[g]), .p_o(p1[g]),
                        .neg_o(n1[g]), .dbl_o(d1[g]));
        qau_sum  u_sum (.aclk(aclk), .en(adv), .p(p1[g]), .neg(n1[g]),
                        .dbl(d1[g]), .acc_o(s1[g]));
    end

    // Carry action and A along pass one (stages 1 to 3) and conjugate data.
    action_t [3:1] act_reg;
    word_t   [3:1][3:0] qa_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            act_reg[1] <= act0_reg;
            qa_reg[1]  <= qa0_reg;
            act_reg[2] <= act_reg[1];
            qa_reg[2]  <= qa_reg[1];
            act_reg[3] <= act_reg[2];
            qa_reg[3]  <= qa_reg[2];
        end
    end

    // Stage 3: round pass one results.
    word_t [8:0] r1_reg;
    logic        sat1_reg;
    always_ff @(posedge aclk) begin
        logic  s;
        logic  any;
        if (adv) begin
            any = 1'b0;
            for (int i = 0; i < 9; i++) begin
                r1_reg[i] <= finish(s1[i], s);
                any = any | s;
            end
            sat1_reg <= any;
        end
    end

    // Pass two term selection: t * conj(A) vector part.
    word_t t0, tt1, tt2, tt3, aw, ax, ay, az;
    assign {t0, tt1, tt2, tt3} = {r1_reg[0], r1_reg[1], r1_reg[2], r1_reg[3]};
    assign {az, ay, ax, aw}    = qa_reg[3];
    term_t [2:0][3:0] t2;
    always_comb begin
        t2[0] = {mk(t0,ax,1,0), mk(tt1,aw,0,0), mk(tt2,az,1,0), mk(tt3,ay,0,0)};
        t2[1] = {mk(t0,ay,1,0), mk(tt2,aw,0,0), mk(tt3,ax,1,0), mk(tt1,az,0,0)};
        t2[2] = {mk(t0,az,1,0), mk(tt3,aw,0,0), mk(tt1,ay,1,0), mk(tt2,ax,0,0)};
    end

    prod_t [2:0][3:0] p2;
    logic  [2:0][3:0] n2, d2;
    acc_t  [2:0]      s2;
    for (genvar g = 0; g < 3; g++) begin : g_p2
        qau_mac4 u_mac (.aclk(aclk), .en(adv), .t(t2[g]), .p_o(p2[g]),
                        .neg_o(n2[g]), .dbl_o(d2[g]));
        qau_sum  u_sum (.aclk(aclk), .en(adv), .p(p2[g]), .neg(n2[g]),
                        .dbl(d2[g]), .acc_o(s2[g]));
    end

    // Delay pass one results across pass two (stages 4 and 5).
    ctl_t  [5:4]      ctl_reg;
    word_t [5:4][8:0] r_reg;
    word_t [5:4][3:0] qd_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_reg[4] <= '{act: act_reg[3], sat: sat1_reg};
            r_reg[4]   <= r1_reg;
            qd_reg[4]  <= qa_reg[3];
            ctl_reg[5] <= ctl_reg[4];
            r_reg[5]   <= r_reg[4];
            qd_reg[5]  <= qd_reg[4];
        end
    end

    // Stage 6: select, round pass two, conjugate; output register.
    word_t [8:0] o_reg;
    logic        osat_reg;
    always_ff @(posedge aclk) begin
        logic        s;
        logic        any;
        word_t       v;
        word_t [8:0] o_v;
        if (adv) begin
            any = ctl_reg[5].sat;
            o_v = '0;
            case (ctl_reg[5].act)
                ACT_PRODUCT: begin
                    o_v[3:0] = r_reg[5][3:0];
                end
                ACT_ROTATE: begin
                    for (int i = 0; i < 3; i++) begin
                        o_v[i] = finish(s2[i], s);
                        any = any | s;
                    end
                end
                ACT_MATRIX: begin
                    o_v = r_reg[5];
                end
                default: begin
                    o_v[0] = qd_reg[5][0];
                    for (int i = 1; i < 4; i++) begin
                        v = qd_reg[5][i];
                        if (v == word_t'(32'sh80000000)) begin
                            o_v[i] = word_t'(32'sh7FFFFFFF);
                            any = 1'b1;
                        end else begin
                            o_v[i] = -v;
                        end
                    end
                end
            endcase
            o_reg    <= o_v;
            osat_reg <= any;
        end
    end

    assign m_valid     = vld_reg[NS-1];
    assign m_out_0     = o_reg[0];
    assign m_out_1     = o_reg[1];
    assign m_out_2     = o_reg[2];
    assign m_out_3     = o_reg[3];
    assign m_out_4     = o_reg[4];
    assign m_out_5     = o_reg[5];
    assign m_out_6     = o_reg[6];
    assign m_out_7     = o_reg[7];
    assign m_out_8     = o_reg[8];
    assign m_saturated = osat_reg;

`ifndef SYNTHESIS
    // A held output must not advance into a new item.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_0) && $stable(m_saturated))
        else $error("output changed while stalled");
    // Input is refused exactly when the output stalls.
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready mismatch");
    // An item accepted while m_ready stays high throughout reaches the output.
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && m_ready ##1 m_ready ##1 m_ready ##1 m_ready
        ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("item lost in pipeline");
`endif
endmodule

>>> tb/sv/quaternion_arith_unit_top_tb.sv
// Testbench for the quaternion unit: random and corner items checked against a predictor.
`timescale 1ns / 100ps

module quaternion_arith_unit_top_tb;
    import qau_pkg::*;

    typedef struct {
        logic signed [31:0] v [9];
        logic sat;
    } quat_result_t;

    // Predicts results of accepted items and checks them in order
    class quat_scoreboard;
        quat_result_t pending_results[$];
        int errors;
        int checked;

        // Round once, then clip to the 32-bit range
        function automatic logic signed [31:0] round_clip(logic signed [67:0] acc,
                                                          ref logic sat);
            logic signed [67:0] r;
            r = (acc + (68'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (r > 68'sh7FFFFFFF) begin
                sat = 1'b1;
                return 32'sh7FFFFFFF;
            end
            if (r < -(68'sd1 <<< 31)) begin
                sat = 1'b1;
                return 32'sh80000000;
            end
            return r[31:0];
        endfunction

        function automatic logic signed [67:0] mul(logic signed [31:0] p,
                                                   logic signed [31:0] q);
            logic signed [67:0] a, b;
            a = p;
            b = q;
            return a * b;
        endfunction

        function void note_input(action_t act, logic signed [31:0] a [4],
                                 logic signed [31:0] b [4]);
            quat_result_t e;
            logic signed [31:0] w, x, y, z, bw, bx, by, bz, t0, t1, t2, t3;
            w = a[0]; x = a[1]; y = a[2]; z = a[3];
            bw = b[0]; bx = b[1]; by = b[2]; bz = b[3];
            e.sat = 1'b0;
            foreach (e.v[i]) e.v[i] = '0;
            case (act)
                ACT_PRODUCT: begin
                    e.v[0] = round_clip(mul(w,bw) - mul(x,bx) - mul(y,by) - mul(z,bz), e.sat);
                    e.v[1] = round_clip(mul(w,bx) + mul(x,bw) + mul(y,bz) - mul(z,by), e.sat);
                    e.v[2] = round_clip(mul(w,by) + mul(y,bw) + mul(z,bx) - mul(x,bz), e.sat);
                    e.v[3] = round_clip(mul(w,bz) + mul(z,bw) + mul(x,by) - mul(y,bx), e.sat);
                end
                ACT_ROTATE: begin
                    t0 = round_clip(-mul(x,bx) - mul(y,by) - mul(z,bz), e.sat);
                    t1 = round_clip(mul(w,bx) + mul(y,bz) - mul(z,by), e.sat);
                    t2 = round_clip(mul(w,by) + mul(z,bx) - mul(x,bz), e.sat);
                    t3 = round_clip(mul(w,bz) + mul(x,by) - mul(y,bx), e.sat);
                    e.v[0] = round_clip(-mul(t0,x) + mul(t1,w) - mul(t2,z) + mul(t3,y), e.sat);
                    e.v[1] = round_clip(-mul(t0,y) + mul(t2,w) - mul(t3,x) + mul(t1,z), e.sat);
                    e.v[2] = round_clip(-mul(t0,z) + mul(t3,w) - mul(t1,y) + mul(t2,x), e.sat);
                end
                ACT_MATRIX: begin
                    e.v[0] = round_clip(mul(w,w) + mul(x,x) - mul(y,y) - mul(z,z), e.sat);
                    e.v[1] = round_clip(2 * (mul(x,y) - mul(w,z)), e.sat);
                    e.v[2] = round_clip(2 * (mul(x,z) + mul(w,y)), e.sat);
                    e.v[3] = round_clip(2 * (mul(x,y) + mul(w,z)), e.sat);
                    e.v[4] = round_clip(mul(w,w) - mul(x,x) + mul(y,y) - mul(z,z), e.sat);
                    e.v[5] = round_clip(2 * (mul(y,z) - mul(w,x)), e.sat);
                    e.v[6] = round_clip(2 * (mul(x,z) - mul(w,y)), e.sat);
                    e.v[7] = round_clip(2 * (mul(y,z) + mul(w,x)), e.sat);
                    e.v[8] = round_clip(mul(w,w) - mul(x,x) - mul(y,y) + mul(z,z), e.sat);
                end
                default: begin
                    e.v[0] = w;
                    for (int i = 1; i < 4; i++) begin
                        if (a[i] == 32'sh80000000) begin
                            e.v[i] = 32'sh7FFFFFFF;
                            e.sat = 1'b1;
                        end else begin
                            e.v[i] = -a[i];
                        end
                    end
                end
            endcase
            pending_results.push_back(e);
        endfunction

        function void check_result(logic signed [31:0] got [9], logic got_sat);
            quat_result_t e;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result item, out_0=%h", $realtime, got[0]);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            checked++;
            for (int i = 0; i < 9; i++)
                if (got[i] !== e.v[i]) begin
                    $display("%0t: out_%0d expected %h actual %h", $realtime, i, e.v[i], got[i]);
                    errors++;
                end
            if (got_sat !== e.sat) begin
                $display("%0t: saturated expected %b actual %b", $realtime, e.sat, got_sat);
                errors++;
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready, m_saturated;
    logic [1:0] s_action;
    logic signed [31:0] s_a_w, s_a_x, s_a_y, s_a_z, s_b_w, s_b_x, s_b_y, s_b_z;
    logic signed [31:0] m_out_0, m_out_1, m_out_2, m_out_3, m_out_4;
    logic signed [31:0] m_out_5, m_out_6, m_out_7, m_out_8;

    quat_scoreboard scoreboard;
    bit calm_sink;
    int op_count [4];

    quaternion_arith_unit_top dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Pick a field value, often a corner
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'sh40000000;
            3: return 32'shC0000000;
            4: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
            5, 6, 7: return $signed($urandom_range(0, 32'h7FFFFFFF)) - 32'sh40000000;
            default: return $urandom;
        endcase
    endfunction

    // Present one item and hold it until accepted
    task automatic send_item(action_t act, logic signed [31:0] a [4],
                             logic signed [31:0] b [4]);
        s_valid <= 1'b1;
        s_action <= act;
        s_a_w <= a[0]; s_a_x <= a[1]; s_a_y <= a[2]; s_a_z <= a[3];
        s_b_w <= b[0]; s_b_x <= b[1]; s_b_y <= b[2]; s_b_z <= b[3];
        do @(posedge aclk); while (!s_ready);
        scoreboard.note_input(act, a, b);
        op_count[act]++;
    endtask

    task automatic send_random(int n, bit gaps);
        logic signed [31:0] a [4], b [4];
        for (int k = 0; k < n; k++) begin
            foreach (a[i]) begin
                a[i] = pick_word();
                b[i] = pick_word();
            end
            send_item(action_t'($urandom_range(0, 3)), a, b);
            if (gaps) while ($urandom_range(0, 99) < 11) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
    endtask

    // Sink side: stall at random, except during the calm stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                scoreboard.check_result('{m_out_0, m_out_1, m_out_2, m_out_3, m_out_4,
                                          m_out_5, m_out_6, m_out_7, m_out_8}, m_saturated);
            m_ready <= calm_sink || ($urandom_range(0, 99) >= 11);
        end
    end

    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic signed [31:0] a [4], b [4];
        int wait_cycles;
        scoreboard = new();
        calm_sink = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = '0;
        {s_a_w, s_a_x, s_a_y, s_a_z, s_b_w, s_b_x, s_b_y, s_b_z} = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners: every action on extremes, identity, unit values
        for (int act = 0; act < 4; act++) begin
            a = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000};
            b = '{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
            send_item(action_t'(act), a, b);
            a = '{32'sh40000000, 0, 0, 0};
            b = '{32'sh12345678, -32'sh0ABCDEF0, 32'sh40000000, 32'sh80000000};
            send_item(action_t'(act), a, b);
            a = '{0, 32'sh80000000, 32'sh80000000, 32'sh80000000};
            b = '{-1, -1, -1, -1};
            send_item(action_t'(act), a, b);
            a = '{32'sh20000000, 32'sh20000000, 32'shE0000000, 32'sh20000000};
            b = '{0, 32'sh40000000, 32'sh00000001, 32'shFFFFFFFF};
            send_item(action_t'(act), a, b);
            a = '{1, -1, 0, 32'sh00000001};
            b = '{32'sh00000001, 32'sh20000000, 32'sh7FFFFFFF, 0};
            send_item(action_t'(act), a, b);
        end

        // Drain completely before resuming
        s_valid <= 1'b0;
        wait_cycles = 0;
        while (scoreboard.pending_results.size() != 0 && wait_cycles < 10000) begin
            @(posedge aclk);
            wait_cycles++;
        end

        send_random(450, 1'b1);
        // Back-to-back stretch with the sink always ready
        calm_sink = 1'b1;
        send_random(150, 1'b0);
        calm_sink = 1'b0;
        send_random(400, 1'b1);
        s_valid <= 1'b0;

        wait_cycles = 0;
        while (scoreboard.pending_results.size() != 0 && wait_cycles < 20000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (20) @(posedge aclk);

        $display("Checked %0d results: %0d product, %0d rotate, %0d matrix, %0d conjugate.",
                 scoreboard.checked, op_count[0], op_count[1], op_count[2], op_count[3]);
        if (scoreboard.errors == 0 && scoreboard.pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", scoreboard.errors,
                     scoreboard.pending_results.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
